FILE: rtl/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared types, constants and helpers for the moving average filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SLOT_W      = $clog2(WINDOW_MAX);
    localparam int WIN_W       = 7;
    localparam int MODE_W      = 2;
    localparam int SAMPLE_W    = 32;
    localparam int HALF_W      = 16;
    localparam int SUM_W       = 40;
    localparam int CNT_W       = $clog2(SUM_W);
    localparam int IN_TDATA_W  = 40;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_MODE = 1'd1;

    // sample modes; the unused code behaves as unsigned 32-bit
    localparam logic [MODE_W-1:0] MODE_U16 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_S16 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_U32 = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // stored pattern seen as a signed sum operand in the given mode
    function automatic logic signed [SUM_W-1:0] sample_value(
        input logic [SAMPLE_W-1:0] bits,
        input logic [MODE_W-1:0]   mode
    );
        logic signed [SUM_W-1:0] val;
        case (mode)
            MODE_U16: val = {{(SUM_W-HALF_W){1'b0}}, bits[HALF_W-1:0]};
            MODE_S16: val = {{(SUM_W-HALF_W){bits[HALF_W-1]}}, bits[HALF_W-1:0]};
            default:  val = {{(SUM_W-SAMPLE_W){1'b0}}, bits};
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/mavg_ram.sv
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mavg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div
// Radix-2 restoring divider, signed dividend by small unsigned divisor,
// quotient truncated toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module mavg_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [mavg_pkg::SUM_W-1:0]   dividend,
    input  logic [mavg_pkg::WIN_W-1:0]          divisor,
    output mavg_pkg::div_stat_t                 stat,
    output logic [mavg_pkg::SUM_W-1:0]          quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          neg_reg, neg_next;
    logic [mavg_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [mavg_pkg::WIN_W-1:0]    rem_reg, rem_next;
    logic [mavg_pkg::SUM_W-1:0]    quo_reg, quo_next;

    logic [mavg_pkg::WIN_W:0]      rem_shift;
    logic [mavg_pkg::WIN_W:0]      rem_sub;
    logic                          fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[mavg_pkg::SUM_W-1]};
        rem_sub   = rem_shift - {1'b0, divisor};
        fits      = (rem_shift >= {1'b0, divisor});

        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[mavg_pkg::SUM_W-1];
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[mavg_pkg::SUM_W-1] ? mavg_pkg::SUM_W'(-dividend)
                                                     : mavg_pkg::SUM_W'(dividend);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[mavg_pkg::WIN_W-1:0] : rem_shift[mavg_pkg::WIN_W-1:0];
            quo_next = {quo_reg[mavg_pkg::SUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mavg_pkg::CNT_W'(mavg_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

FILE: rtl/moving_average_filter.sv
// ----------------------------------------------------------------------------
// moving_average_filter
// Running-sum moving average over a slot-addressed sample window.
// ----------------------------------------------------------------------------
// Sequence: a good item passes subtract, add, divider start, the divider steps,
//   done handoff and output load; a rejected slot goes straight to output load.
//   The block takes no new item until the last one has gone to the output
//   register, and a stalled output holds the item in output load.
//   Ready is low while an item is in flight.
// Reset (async, active low): sum cleared, all slots read as zero via per-slot
//   valid bits, window_size 1, sample_mode 0, output empty.
// ----------------------------------------------------------------------------
module moving_average_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mavg_pkg::IN_TDATA_W-1:0]      s_tdata,   // sample_bits[31:0], slot_index[37:32]
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mavg_pkg::SAMPLE_W-1:0]        m_tdata,   // average_bits[31:0]
    output logic                                 m_tuser,   // slot_error[0]
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mavg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mavg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // ---------------- registers ----------------
    mavg_pkg::state_t                     state_reg, state_next;
    logic [mavg_pkg::WIN_W-1:0]           win_reg, win_next;
    logic [mavg_pkg::MODE_W-1:0]          mode_reg, mode_next;
    logic [mavg_pkg::SUM_W-1:0]           sum_reg, sum_next;
    logic [mavg_pkg::WINDOW_MAX-1:0]      valid_reg, valid_next;
    logic [mavg_pkg::SAMPLE_W-1:0]        sample_reg, sample_next;
    logic [mavg_pkg::SLOT_W-1:0]          slot_reg, slot_next;
    logic                                 err_reg, err_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [mavg_pkg::SAMPLE_W-1:0]        out_data_reg, out_data_next;
    logic                                 out_err_reg, out_err_next;

    // ---------------- datapath wires ----------------
    logic [mavg_pkg::WIN_W-1:0]           eff_win;     // window_size clamped to WINDOW_MAX
    logic [mavg_pkg::SAMPLE_W-1:0]        in_sample;
    logic [mavg_pkg::SLOT_W-1:0]          in_slot;
    logic                                 in_accept;
    logic                                 in_bad;
    logic [mavg_pkg::SAMPLE_W-1:0]        stored_bits; // what goes into the slot
    logic [mavg_pkg::SAMPLE_W-1:0]        old_bits;
    logic [mavg_pkg::SAMPLE_W-1:0]        ram_rdata;
    logic [mavg_pkg::SLOT_W-1:0]          ram_raddr;
    logic                                 ram_we;
    logic                                 div_start;
    mavg_pkg::div_stat_t                  div_stat;
    logic [mavg_pkg::SUM_W-1:0]           div_quo;
    logic [mavg_pkg::SAMPLE_W-1:0]        avg_bits;
    logic                                 out_free;

    assign in_sample = s_tdata[mavg_pkg::SAMPLE_W-1:0];
    assign in_slot   = s_tdata[mavg_pkg::SAMPLE_W +: mavg_pkg::SLOT_W];

    assign eff_win = (win_reg > mavg_pkg::WIN_W'(mavg_pkg::WINDOW_MAX))
                     ? mavg_pkg::WIN_W'(mavg_pkg::WINDOW_MAX) : win_reg;

    // zero window rejects every slot as well
    assign in_bad = ({1'b0, in_slot} >= eff_win);

    assign s_tready  = (state_reg == mavg_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    // writes only land with nothing in flight; a waiting item goes first
    assign cfg_ready = (state_reg == mavg_pkg::ST_IDLE) && !s_tvalid;

    // 16-bit modes keep only the low half in the store
    assign stored_bits = (mode_reg == mavg_pkg::MODE_U16 || mode_reg == mavg_pkg::MODE_S16)
                         ? {{(mavg_pkg::SAMPLE_W-mavg_pkg::HALF_W){1'b0}},
                            sample_reg[mavg_pkg::HALF_W-1:0]}
                         : sample_reg;

    // read address follows the incoming slot so data is ready in the next cycle
    assign ram_raddr = (state_reg == mavg_pkg::ST_IDLE) ? in_slot : slot_reg;
    assign ram_we    = (state_reg == mavg_pkg::ST_SUB);
    assign old_bits  = valid_reg[slot_reg] ? ram_rdata : '0;
    assign div_start = (state_reg == mavg_pkg::ST_DIV_START);

    assign avg_bits = (mode_reg == mavg_pkg::MODE_U16 || mode_reg == mavg_pkg::MODE_S16)
                      ? {{(mavg_pkg::SAMPLE_W-mavg_pkg::HALF_W){1'b0}},
                         div_quo[mavg_pkg::HALF_W-1:0]}
                      : div_quo[mavg_pkg::SAMPLE_W-1:0];

    assign out_free = !out_valid_reg || m_tready;

    mavg_ram #(
        .WIDTH (mavg_pkg::SAMPLE_W),
        .DEPTH (mavg_pkg::WINDOW_MAX)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (stored_bits),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mavg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (eff_win),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        mode_next      = mode_reg;
        sum_next       = sum_reg;
        valid_next     = valid_reg;
        sample_next    = sample_reg;
        slot_next      = slot_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // register writes; only issued while idle
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mavg_pkg::REG_WINDOW_SIZE: win_next  = cfg_data[mavg_pkg::WIN_W-1:0];
                mavg_pkg::REG_SAMPLE_MODE: mode_next = cfg_data[mavg_pkg::MODE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            mavg_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = in_sample;
                    slot_next   = in_slot;
                    err_next    = in_bad;
                    state_next  = in_bad ? mavg_pkg::ST_EMIT : mavg_pkg::ST_SUB;
                end
            end
            mavg_pkg::ST_SUB:
            begin
                // retire the old sample and store the new one
                sum_next             = sum_reg - mavg_pkg::sample_value(old_bits, mode_reg);
                valid_next[slot_reg] = 1'b1;
                state_next           = mavg_pkg::ST_ADD;
            end
            mavg_pkg::ST_ADD:
            begin
                sum_next   = sum_reg + mavg_pkg::sample_value(stored_bits, mode_reg);
                state_next = mavg_pkg::ST_DIV_START;
            end
            mavg_pkg::ST_DIV_START:
            begin
                state_next = mavg_pkg::ST_DIV_WAIT;
            end
            mavg_pkg::ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = mavg_pkg::ST_EMIT;
                end
            end
            mavg_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = err_reg ? '0 : avg_bits;
                    out_err_next   = err_reg;
                    state_next     = mavg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mavg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mavg_pkg::ST_IDLE;
            win_reg       <= mavg_pkg::WIN_W'(1);
            mode_reg      <= mavg_pkg::MODE_U16;
            sum_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            mode_reg      <= mode_next;
            sum_reg       <= sum_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        slot_reg     <= slot_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    // ---------------- assertions ----------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("rejected slot result carries nonzero average");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == mavg_pkg::ST_DIV_WAIT))
        else $error("divider finished outside the wait state");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == mavg_pkg::ST_SUB || state_reg == mavg_pkg::ST_EMIT))
        else $error("accepted item did not start processing");

    a_slot_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mavg_pkg::ST_SUB) |=> valid_reg[$past(slot_reg)])
        else $error("written slot not marked valid");

endmodule

FILE: test/tb_moving_average_filter.sv
// ----------------------------------------------------------------------------
// tb_moving_average_filter
// Self-checking bench for the running-sum moving average filter. Items are
// queued by the stimulus block and fed by a stream driver. A scoreboard
// mirrors the sample store, running sum and registers to predict each
// average. Results are checked in order as they leave the block.
// ----------------------------------------------------------------------------
module tb_moving_average_filter;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 60;
    // unused mode code, behaves as unsigned 32-bit
    localparam logic [mavg_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [mavg_pkg::SAMPLE_W-1:0] sample;
        logic [mavg_pkg::SLOT_W-1:0]   slot;
    } in_item_t;

    typedef struct {
        logic [mavg_pkg::SAMPLE_W-1:0] average;
        logic                          slot_err;
    } avg_result_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [mavg_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [mavg_pkg::SAMPLE_W-1:0]    m_tdata;
    logic                             m_tuser;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [mavg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mavg_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // scoreboard copy of the block state and registers
    logic [mavg_pkg::SAMPLE_W-1:0]    window_store [mavg_pkg::WINDOW_MAX];
    logic [mavg_pkg::SUM_W-1:0]       window_sum;
    logic [mavg_pkg::WIN_W-1:0]       window_size_reg;
    logic [mavg_pkg::MODE_W-1:0]      sample_mode_reg;

    in_item_t               pending_items[$];
    avg_result_t            expected_averages[$];

    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     mismatch_count = 0;
    int                     cycle_count = 0;

    moving_average_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard model
    // ------------------------------------------------------------------------

    // stored pattern as seen by the given mode
    function automatic longint operand_of(input logic [mavg_pkg::SAMPLE_W-1:0] bits,
                                          input logic [mavg_pkg::MODE_W-1:0] mode);
        longint v;
        if (mode == mavg_pkg::MODE_U16)
            v = bits[mavg_pkg::HALF_W-1:0];
        else if (mode == mavg_pkg::MODE_S16)
            v = $signed(bits[mavg_pkg::HALF_W-1:0]);
        else
            v = bits;
        return v;
    endfunction

    function automatic int effective_window();
        return (window_size_reg > mavg_pkg::WINDOW_MAX) ? mavg_pkg::WINDOW_MAX
                                                        : int'(window_size_reg);
    endfunction

    function automatic void predict_average(input logic [mavg_pkg::SAMPLE_W-1:0] sample,
                                            input logic [mavg_pkg::SLOT_W-1:0] slot);
        avg_result_t                   res;
        logic [mavg_pkg::MODE_W-1:0]   mode;
        logic [mavg_pkg::SAMPLE_W-1:0] kept;
        longint                        acc;
        longint                        quot;
        int                            eff;
        eff  = effective_window();
        mode = (sample_mode_reg == mavg_pkg::MODE_U16 || sample_mode_reg == mavg_pkg::MODE_S16)
               ? sample_mode_reg : mavg_pkg::MODE_U32;
        if (eff == 0 || int'(slot) >= eff)
        begin
            // rejected slot: nothing updated
            res.average  = '0;
            res.slot_err = 1'b1;
        end
        else
        begin
            kept = (mode == mavg_pkg::MODE_U32)
                   ? sample : {{mavg_pkg::HALF_W{1'b0}}, sample[mavg_pkg::HALF_W-1:0]};
            acc  = $signed(window_sum);
            acc  = acc - operand_of(window_store[slot], mode) + operand_of(kept, mode);
            window_sum         = acc[mavg_pkg::SUM_W-1:0];
            window_store[slot] = kept;
            // sum is always signed; quotient truncates toward zero
            acc  = $signed(window_sum);
            quot = acc / longint'(eff);
            res.average  = (mode == mavg_pkg::MODE_U32)
                           ? quot[mavg_pkg::SAMPLE_W-1:0]
                           : {{mavg_pkg::HALF_W{1'b0}}, quot[mavg_pkg::HALF_W-1:0]};
            res.slot_err = 1'b0;
        end
        expected_averages.push_back(res);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Input driver: holds tvalid until accepted, idles at random between items
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        in_item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_average(s_tdata[mavg_pkg::SAMPLE_W-1:0],
                                s_tdata[mavg_pkg::SAMPLE_W +: mavg_pkg::SLOT_W]);
            if ((!s_tvalid || s_tready) && pending_items.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = pending_items.pop_front();
                s_tdata  <= {{(mavg_pkg::IN_TDATA_W-mavg_pkg::SAMPLE_W-mavg_pkg::SLOT_W){1'b0}},
                             nxt.slot, nxt.sample};
                s_tvalid <= 1'b1;
            end
            else if (s_tready)
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: random backpressure, in-order compare
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_results
        avg_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_averages.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item avg=%h err=%b",
                                              m_tdata, m_tuser));
                end
                else
                begin
                    want = expected_averages.pop_front();
                    if (m_tdata !== want.average)
                        report_mismatch($sformatf("average_bits got %h want %h",
                                                  m_tdata, want.average));
                    if (m_tuser !== want.slot_err)
                        report_mismatch($sformatf("slot_error got %b want %b",
                                                  m_tuser, want.slot_err));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [mavg_pkg::SAMPLE_W-1:0] sample,
                             input logic [mavg_pkg::SLOT_W-1:0] slot);
        in_item_t it;
        it.sample = sample;
        it.slot   = slot;
        pending_items.push_back(it);
    endtask

    // checked between edges so the driver's updates have settled
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_averages.size() > 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [mavg_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [mavg_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // write lands at this edge; mirror it
        if (idx == mavg_pkg::REG_WINDOW_SIZE)
            window_size_reg = data[mavg_pkg::WIN_W-1:0];
        else
            sample_mode_reg = data[mavg_pkg::MODE_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [mavg_pkg::SAMPLE_W-1:0] pick_sample();
        logic [mavg_pkg::SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = {16'($urandom_range(0, 65535)), 16'h8000};
            3:       v = 32'h0000_7FFF;
            4:       v = {16'($urandom_range(0, 65535)), 16'hFFFF};
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [mavg_pkg::SLOT_W-1:0] pick_slot();
        int eff;
        eff = effective_window();
        if (eff > 0 && $urandom_range(0, 99) < 88)
            return mavg_pkg::SLOT_W'($urandom_range(0, eff - 1));
        return mavg_pkg::SLOT_W'($urandom_range(0, mavg_pkg::WINDOW_MAX - 1));
    endfunction

    initial
    begin
        int                          n_items;
        logic [mavg_pkg::WIN_W-1:0]  win;
        logic [mavg_pkg::MODE_W-1:0] mode;

        for (int i = 0; i < mavg_pkg::WINDOW_MAX; i++)
            window_store[i] = '0;
        window_sum      = '0;
        window_size_reg = 7'd1;
        sample_mode_reg = mavg_pkg::MODE_U16;

        send_idle_pct = 25;
        recv_idle_pct = 74;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset defaults: window of one, unsigned 16-bit; slot 1 rejected
        push_item(32'hFFFF_FFFF, 6'd0);
        push_item(32'h0000_1234, 6'd1);
        wait_drained();

        // full window, signed: most negative, most positive, minus one
        write_register(mavg_pkg::REG_WINDOW_SIZE, 7'd64);
        write_register(mavg_pkg::REG_SAMPLE_MODE, {5'd0, mavg_pkg::MODE_S16});
        push_item(32'h0000_8000, 6'd63);
        push_item(32'h0000_7FFF, 6'd0);
        push_item(32'hFFFF_FFFF, 6'd5);
        for (int i = 1; i <= 4; i++)
            push_item(32'hABCD_8000, mavg_pkg::SLOT_W'(i));
        push_item(32'h1234_8001, 6'd6);
        wait_drained();

        // mode change under stored data; sum stays negative in unsigned mode
        write_register(mavg_pkg::REG_SAMPLE_MODE, {5'd0, mavg_pkg::MODE_U16});
        push_item(32'h0000_0000, 6'd63);
        push_item(32'h0000_FFFF, 6'd10);
        wait_drained();

        // oversized window clamps to the maximum; spare mode code as 32-bit
        write_register(mavg_pkg::REG_WINDOW_SIZE, 7'd127);
        write_register(mavg_pkg::REG_SAMPLE_MODE, {5'd0, MODE_SPARE});
        push_item(32'hFFFF_FFFF, 6'd63);
        push_item(32'hFFFF_FFFF, 6'd62);
        push_item(32'h0000_0000, 6'd0);
        wait_drained();

        // zero window rejects everything
        write_register(mavg_pkg::REG_WINDOW_SIZE, 7'd0);
        push_item(32'h0000_0000, 6'd0);
        push_item(32'hFFFF_FFFF, 6'd63);
        wait_drained();

        // upper data bits on a mode write are ignored; slot just past window
        write_register(mavg_pkg::REG_WINDOW_SIZE, 7'd40);
        write_register(mavg_pkg::REG_SAMPLE_MODE, {5'h1F, mavg_pkg::MODE_U32});
        push_item(32'hDEAD_BEEF, 6'd40);
        push_item(32'h8000_0000, 6'd39);
        wait_drained();

        // random phases, each with its own settings
        for (int p = 0; p < 16; p++)
        begin
            case (p)
                0:       win = 7'd64;
                1:       win = 7'd1;
                2:       win = 7'd127;
                3:       win = 7'd0;
                default: win = ($urandom_range(0, 7) == 0)
                               ? mavg_pkg::WIN_W'($urandom_range(65, 127))
                               : mavg_pkg::WIN_W'($urandom_range(2, 64));
            endcase
            mode = mavg_pkg::MODE_W'($urandom_range(0, 3));
            if (p < 5)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 74;
            end
            else if (p < 10)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_register(mavg_pkg::REG_WINDOW_SIZE, win);
            write_register(mavg_pkg::REG_SAMPLE_MODE, {5'($urandom_range(0, 31)), mode});
            n_items = (win == 0) ? 20 : 100;
            for (int k = 0; k < n_items; k++)
                push_item(pick_sample(), pick_slot());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
